[sv/wcid_pkg.sv]
// Package for the window count intersection detector.
// Holds shared constants, register index codes and the lane result type.
// No dependencies.
package wcid_pkg;

  localparam int WCID_WINDOW_LEN = 16;
  localparam int TIME_W          = 32;
  localparam int THR_W           = 5;
  localparam int LOCK_W          = 16;
  localparam int TOTAL_W         = 16;
  localparam int ONES_W          = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [THR_W-1:0]  THR_RESET  = 5'd8;
  localparam logic [LOCK_W-1:0] LOCK_RESET = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_THRESHOLD = 2'd0,
    REG_LOCKOUT_TIME    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic               found;
    logic [TOTAL_W-1:0] total;
    logic [ONES_W-1:0]  ones;
  } lane_res_t;

endpackage

[sv/wcid_lane.sv]
// One sensor lane: gated sliding window, ones count, lockout and total.
// Depends on wcid_pkg.
module wcid_lane #(
  parameter int WINDOW_LEN = wcid_pkg::WCID_WINDOW_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [wcid_pkg::TIME_W-1:0] now_time,
  input  logic                        line,
  input  logic [wcid_pkg::THR_W-1:0]  threshold,
  input  logic [wcid_pkg::LOCK_W-1:0] lockout,
  output wcid_pkg::lane_res_t         res
);
  import wcid_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  logic [WINDOW_LEN-1:0] win_r, win_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  armed_r, armed_nxt;
  logic [TIME_W-1:0]     mark_r, mark_nxt;
  logic [TOTAL_W-1:0]    seen_r, seen_nxt;

  logic                  gated;
  logic [CNT_W-1:0]      cnt_upd;
  logic [TIME_W-1:0]     elapsed;
  logic                  rearm;
  logic                  hit;

  always_comb begin
    gated   = armed_r & line;
    cnt_upd = cnt_r + CNT_W'(gated) - CNT_W'(win_r[WINDOW_LEN-1]);
    elapsed = now_time - mark_r;
    rearm   = elapsed > TIME_W'(lockout);
    hit     = CMP_W'(cnt_upd) == CMP_W'(threshold);
    if (hit) begin
      win_nxt   = '0;
      cnt_nxt   = '0;
      armed_nxt = 1'b0;
      mark_nxt  = now_time;
      seen_nxt  = seen_r + TOTAL_W'(1);
    end else begin
      win_nxt   = {win_r[WINDOW_LEN-2:0], gated};
      cnt_nxt   = cnt_upd;
      armed_nxt = armed_r | rearm;
      mark_nxt  = mark_r;
      seen_nxt  = seen_r;
    end
    res.found = hit;
    res.total = seen_nxt;
    res.ones  = ONES_W'(CMP_W'(cnt_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      cnt_r   <= '0;
      armed_r <= 1'b1;
      mark_r  <= '0;
      seen_r  <= '0;
    end else if (adv) begin
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
      mark_r  <= mark_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[sv/wcid_merge.sv]
// Merge stage: joins both lane results into one output beat register.
// Depends on wcid_pkg.
module wcid_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                out_ready,
  input  wcid_pkg::lane_res_t left_res,
  input  wcid_pkg::lane_res_t right_res,
  output logic                out_valid,
  output logic                hold,
  output wcid_pkg::lane_res_t left_q,
  output wcid_pkg::lane_res_t right_q
);
  import wcid_pkg::*;

  logic      valid_r, valid_nxt;
  lane_res_t left_r, right_r;

  always_comb begin
    hold      = valid_r & ~out_ready;
    valid_nxt = load | hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_valid = valid_r;
  assign left_q    = left_r;
  assign right_q   = right_r;

endmodule

[sv/window_count_intersection_detector_top.sv]
// Two-lane intersection detector top level: config registers, lanes, merge.
// Accepted beat is output the next cycle; one beat per cycle unless the output stalls.
// The output register frees each cycle its beat is taken, so input and output overlap.
// Reset (rst_n low, synchronous): windows, counts, totals and marks cleared, lanes armed,
// threshold 8, lockout 500, no output beat pending. Depends on wcid_pkg.
module window_count_intersection_detector_top #(
  parameter int WINDOW_LEN = wcid_pkg::WCID_WINDOW_LEN
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [wcid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcid_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wcid_pkg::TIME_W-1:0]     in_now_time,
  input  logic                            in_left_line,
  input  logic                            in_right_line,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_left_found,
  output logic                            out_right_found,
  output logic [wcid_pkg::TOTAL_W-1:0]    out_left_total,
  output logic [wcid_pkg::TOTAL_W-1:0]    out_right_total,
  output logic [wcid_pkg::ONES_W-1:0]     out_left_ones,
  output logic [wcid_pkg::ONES_W-1:0]     out_right_ones
);
  import wcid_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [LOCK_W-1:0] lock_r;
  logic              adv;
  logic              hold;
  lane_res_t         left_res, right_res, left_q, right_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      lock_r <= LOCK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_THRESHOLD: thr_r  <= cfg_wdata[THR_W-1:0];
        REG_LOCKOUT_TIME:    lock_r <= cfg_wdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = ~hold;
  assign adv      = in_valid & in_ready;

  wcid_lane #(.WINDOW_LEN(WINDOW_LEN)) u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .now_time  (in_now_time),
    .line      (in_left_line),
    .threshold (thr_r),
    .lockout   (lock_r),
    .res       (left_res)
  );

  wcid_lane #(.WINDOW_LEN(WINDOW_LEN)) u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .now_time  (in_now_time),
    .line      (in_right_line),
    .threshold (thr_r),
    .lockout   (lock_r),
    .res       (right_res)
  );

  wcid_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv),
    .out_ready (out_ready),
    .left_res  (left_res),
    .right_res (right_res),
    .out_valid (out_valid),
    .hold      (hold),
    .left_q    (left_q),
    .right_q   (right_q)
  );

  assign out_left_found  = left_q.found;
  assign out_right_found = right_q.found;
  assign out_left_total  = left_q.total;
  assign out_right_total = right_q.total;
  assign out_left_ones   = left_q.ones;
  assign out_right_ones  = right_q.ones;

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat did not reach the output");

  a_left_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_found |-> out_left_ones == '0)
    else $error("left detection left ones in window");

  a_right_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_right_found |-> out_right_ones == '0)
    else $error("right detection left ones in window");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat pending after reset");

endmodule
